// ===== design/set_associative_cache_tag_store_macros.svh =====
// Assertion macros shared by the tag store RTL.
// SACTS_ASSERT_IMP checks a same-cycle implication, SACTS_ASSERT_NXT a next-cycle one.
`ifndef SET_ASSOCIATIVE_CACHE_TAG_STORE_MACROS_SVH
`define SET_ASSOCIATIVE_CACHE_TAG_STORE_MACROS_SVH
`ifndef SYNTHESIS
`define SACTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tag store check failed");
`define SACTS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tag store check failed");
`else
`define SACTS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SACTS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/sacts_pkg.sv =====
`timescale 1ns / 1ps
package sacts_pkg;

  // Defaults of the top-level parameters
  localparam int MAX_SETS_DEF = 256;
  localparam int WAYS_DEF     = 8;

  // Fixed field widths
  localparam int ADDR_BITS = 32;
  localparam int TIME_BITS = 32;
  localparam int CFG_W     = 4;
  localparam int WAY_OUT_W = 3;
  localparam int SET_OUT_W = 8;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Register indexes
  localparam logic [1:0] REG_BLOCK_SIZE_LOG2 = 2'd0;
  localparam logic [1:0] REG_SET_COUNT_LOG2  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE     = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] BLOCK_SIZE_LOG2_RST = 4'd6;
  localparam logic [CFG_W-1:0] SET_COUNT_LOG2_RST  = 4'd6;
  localparam logic [CFG_W-1:0] WAYS_IN_USE_RST     = 4'd8;

  // Transaction kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] block_size_log2;
    logic [CFG_W-1:0] set_count_log2;
    logic [CFG_W-1:0] ways_in_use;
  } cfg_t;

  // Largest n with 2**n <= value, evaluated at elaboration
  function automatic int floor_log2(input int value);
    int n;
    n = 0;
    while (n < 30 && (1 << (n + 1)) <= value) begin
      n = n + 1;
    end
    return n;
  endfunction

endpackage

// ===== design/sacts_cfg.sv =====
`timescale 1ns / 1ps
module sacts_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sacts_pkg::PADDR_W-1:0] paddr,
  input  logic [sacts_pkg::PDATA_W-1:0] pwdata,
  output logic [sacts_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output sacts_pkg::cfg_t               cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Update the addressed register on the access phase of a write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size_log2 <= sacts_pkg::BLOCK_SIZE_LOG2_RST;
      cfg.set_count_log2  <= sacts_pkg::SET_COUNT_LOG2_RST;
      cfg.ways_in_use     <= sacts_pkg::WAYS_IN_USE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        sacts_pkg::REG_BLOCK_SIZE_LOG2: cfg.block_size_log2 <= pwdata[sacts_pkg::CFG_W-1:0];
        sacts_pkg::REG_SET_COUNT_LOG2:  cfg.set_count_log2  <= pwdata[sacts_pkg::CFG_W-1:0];
        sacts_pkg::REG_WAYS_IN_USE:     cfg.ways_in_use     <= pwdata[sacts_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Return the addressed register, zero elsewhere
  always_comb begin
    prdata = '0;
    case (reg_idx)
      sacts_pkg::REG_BLOCK_SIZE_LOG2: prdata[sacts_pkg::CFG_W-1:0] = cfg.block_size_log2;
      sacts_pkg::REG_SET_COUNT_LOG2:  prdata[sacts_pkg::CFG_W-1:0] = cfg.set_count_log2;
      sacts_pkg::REG_WAYS_IN_USE:     prdata[sacts_pkg::CFG_W-1:0] = cfg.ways_in_use;
      default:                        prdata = '0;
    endcase
  end

endmodule

// ===== design/sacts_mem.sv =====
`timescale 1ns / 1ps
module sacts_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int WIDTH = 516
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sacts_victim.sv =====
`timescale 1ns / 1ps
module sacts_victim #(
  parameter int WAYS   = 8,
  parameter int TIME_W = 32,
  parameter int WAY_W  = 3
) (
  input  logic [WAYS*TIME_W-1:0] times,
  input  logic [WAYS-1:0]        active,
  output logic [WAY_W-1:0]       victim
);

  localparam int LEAVES = 1 << $clog2(WAYS);

  logic              node_ok   [2*LEAVES];
  logic [TIME_W-1:0] node_time [2*LEAVES];
  logic [WAY_W-1:0]  node_way  [2*LEAVES];

  // Pairwise minimum tree; the left side keeps ties so the lowest way wins
  always_comb begin
    for (int n = 0; n < 2 * LEAVES; n++) begin
      node_ok[n]   = 1'b0;
      node_time[n] = '0;
      node_way[n]  = '0;
    end
    for (int i = 0; i < WAYS; i++) begin
      node_ok[LEAVES + i]   = active[i];
      node_time[LEAVES + i] = times[i*TIME_W +: TIME_W];
      node_way[LEAVES + i]  = WAY_W'(i);
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (!node_ok[2*n] ||
          (node_ok[2*n+1] && node_time[2*n+1] < node_time[2*n])) begin
        node_ok[n]   = node_ok[2*n+1];
        node_time[n] = node_time[2*n+1];
        node_way[n]  = node_way[2*n+1];
      end else begin
        node_ok[n]   = node_ok[2*n];
        node_time[n] = node_time[2*n];
        node_way[n]  = node_way[2*n];
      end
    end
    victim = node_way[1];
  end

endmodule

// ===== design/set_associative_cache_tag_store.sv =====
// An accepted transaction reads its set row into the registered memory output;
// its result is registered once the response register is free or being drained,
// and only then is a new one taken (read, then compare and update of the set row).
// Reset: the registers return to 6, 6 and 8, then a clearing pass of one set per
// cycle over 2**floor(log2(MAX_SETS)) sets (256 at defaults) zeroes the fill counts.
`timescale 1ns / 1ps
`include "set_associative_cache_tag_store_macros.svh"
module set_associative_cache_tag_store #(
  parameter int MAX_SETS = sacts_pkg::MAX_SETS_DEF,
  parameter int WAYS     = sacts_pkg::WAYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            kind,
  input  logic [sacts_pkg::ADDR_BITS-1:0] address,
  input  logic [sacts_pkg::TIME_BITS-1:0] access_time,
  // response channel
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            hit,
  output logic [sacts_pkg::WAY_OUT_W-1:0] way_index,
  output logic [sacts_pkg::SET_OUT_W-1:0] set_index,
  output logic [sacts_pkg::ADDR_BITS-1:0] tag_value,
  output logic                            evicted,
  output logic [sacts_pkg::ADDR_BITS-1:0] evicted_tag,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sacts_pkg::PADDR_W-1:0]   paddr,
  input  logic [sacts_pkg::PDATA_W-1:0]   pwdata,
  output logic [sacts_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);

  localparam int SET_LOG2  = sacts_pkg::floor_log2(MAX_SETS);
  localparam int NSETS     = 1 << SET_LOG2;
  localparam int SET_W     = (SET_LOG2 > 0) ? SET_LOG2 : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W    = $clog2(WAYS + 1);
  localparam int TAG_W     = sacts_pkg::ADDR_BITS;
  localparam int TIME_W    = sacts_pkg::TIME_BITS;
  localparam int TIME_BASE = WAYS * TAG_W;
  localparam int FILL_BASE = WAYS * (TAG_W + TIME_W);
  localparam int ROW_W     = FILL_BASE + FILL_W;

  sacts_pkg::cfg_t cfg;

  // Control state
  logic             clearing;
  logic [SET_W-1:0] clr_addr;
  logic             busy;

  // Transaction held while it is compared and updated
  logic              item_kind;
  logic [SET_W-1:0]  item_set;
  logic [TAG_W-1:0]  item_tag;
  logic [TIME_W-1:0] item_time;

  // Address split
  logic                        req_acc;
  logic [sacts_pkg::CFG_W-1:0] sbits;
  logic [TAG_W-1:0]            block_addr;
  logic [TAG_W-1:0]            set_full;
  logic [SET_W-1:0]            req_set;
  logic [TAG_W-1:0]            req_tag;

  // Row access
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] upd_row;
  logic [ROW_W-1:0] wr_row;
  logic [SET_W-1:0] wr_addr;
  logic             wr_en;

  // Compare and update
  logic [FILL_W-1:0] ways_c;
  logic [FILL_W-1:0] fill_raw;
  logic [FILL_W-1:0] fill_c;
  logic [WAYS-1:0]   match;
  logic [WAYS-1:0]   active;
  logic              hit_any;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  victim;
  logic              set_full_now;
  logic [WAY_W-1:0]  ins_way;
  logic [TAG_W-1:0]  old_tag;
  logic [WAY_W-1:0]  way_sel;
  logic [31:0]       way_wide;
  logic [31:0]       set_wide;
  logic              load;

  sacts_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Take a transaction only when idle and the fill counts are cleared
  assign req_stall = clearing | busy;
  assign req_acc   = req_valid & ~req_stall;

  // Split the address into set and tag
  always_comb begin
    if (32'(cfg.set_count_log2) > SET_LOG2) begin
      sbits = sacts_pkg::CFG_W'(SET_LOG2);
    end else begin
      sbits = cfg.set_count_log2;
    end
    block_addr = address >> cfg.block_size_log2;
    set_full   = block_addr & ~({TAG_W{1'b1}} << sbits);
    req_set    = set_full[SET_W-1:0];
    req_tag    = block_addr >> sbits;
  end

  // Sweep the sets after reset, then track one transaction at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      busy     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == SET_W'(NSETS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (req_acc) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (req_acc) begin
      item_kind <= kind;
      item_set  <= req_set;
      item_tag  <= req_tag;
      item_time <= access_time;
    end
  end

  sacts_mem #(
    .DEPTH (NSETS),
    .AW    (SET_W),
    .WIDTH (ROW_W)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_row),
    .re    (req_acc),
    .raddr (req_set),
    .rdata (rd_row)
  );

  // Clamp ways in use and the stored fill count
  always_comb begin
    if (cfg.ways_in_use == '0) begin
      ways_c = FILL_W'(1);
    end else if (32'(cfg.ways_in_use) > WAYS) begin
      ways_c = FILL_W'(WAYS);
    end else begin
      ways_c = FILL_W'(cfg.ways_in_use);
    end
    fill_raw = rd_row[FILL_BASE +: FILL_W];
    fill_c   = (fill_raw > ways_c) ? ways_c : fill_raw;
  end

  // Compare tags of the filled ways; lowest matching way wins
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w]  = (FILL_W'(w) < fill_c) && (rd_row[w*TAG_W +: TAG_W] == item_tag);
      active[w] = FILL_W'(w) < ways_c;
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    hit_any = |match;
  end

  sacts_victim #(
    .WAYS   (WAYS),
    .TIME_W (TIME_W),
    .WAY_W  (WAY_W)
  ) u_victim (
    .times  (rd_row[TIME_BASE +: WAYS*TIME_W]),
    .active (active),
    .victim (victim)
  );

  // Build the updated row for an insert
  always_comb begin
    set_full_now = (fill_c == ways_c);
    ins_way      = set_full_now ? victim : fill_c[WAY_W-1:0];
    upd_row      = rd_row;
    old_tag      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == ins_way) begin
        old_tag                                = rd_row[w*TAG_W +: TAG_W];
        upd_row[w*TAG_W +: TAG_W]              = item_tag;
        upd_row[TIME_BASE + w*TIME_W +: TIME_W] = item_time;
      end
    end
    if (!set_full_now) begin
      upd_row[FILL_BASE +: FILL_W] = fill_c + 1'b1;
    end
  end

  // Finish when the response register is free or being drained
  assign load = busy & (~rsp_valid | ~rsp_stall);

  // Memory write: clearing pass, or write-back of an insert
  always_comb begin
    wr_en   = clearing | (load & (item_kind == sacts_pkg::KIND_INSERT));
    wr_addr = clearing ? clr_addr : item_set;
    wr_row  = clearing ? '0 : upd_row;
  end

  // Select the reported way and widen for the fixed output fields
  always_comb begin
    if (item_kind == sacts_pkg::KIND_INSERT) begin
      way_sel = ins_way;
    end else if (hit_any) begin
      way_sel = hit_way;
    end else begin
      way_sel = '0;
    end
    way_wide = 32'(way_sel);
    set_wide = 32'(item_set);
  end

  // Response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (load) begin
      hit         <= (item_kind == sacts_pkg::KIND_LOOKUP) & hit_any;
      way_index   <= way_wide[sacts_pkg::WAY_OUT_W-1:0];
      set_index   <= set_wide[sacts_pkg::SET_OUT_W-1:0];
      tag_value   <= item_tag;
      evicted     <= (item_kind == sacts_pkg::KIND_INSERT) & set_full_now;
      evicted_tag <= ((item_kind == sacts_pkg::KIND_INSERT) & set_full_now) ? old_tag : '0;
    end
  end

  `SACTS_ASSERT_NXT(a_accept_busy, clk, rst, req_acc, busy)
  `SACTS_ASSERT_IMP(a_rsp_from_busy, clk, rst, $rose(rsp_valid), $past(busy))
  `SACTS_ASSERT_IMP(a_hit_no_evict, clk, rst, rsp_valid && hit, !evicted)
  `SACTS_ASSERT_IMP(a_evict_tag_zero, clk, rst, rsp_valid && !evicted, evicted_tag == '0)
  `SACTS_ASSERT_IMP(a_no_write_idle, clk, rst, wr_en, clearing || busy)

endmodule
